// File: src/rbfp_pkg.sv
// ----------------------------------------------------------------------------
// rbfp_pkg: shared types and constants for the row bit field packer
// Payload structs, attribute kind codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rbfp_pkg;

  // default geometry of a row
  localparam int ITEM_BITS_DEF = 32;
  localparam int MAX_ITEMS_DEF = 64;

  // field widths
  localparam int KIND_W   = 3;
  localparam int REQ_W    = 7;
  localparam int PTR_W    = 7;
  localparam int OFF_W    = 11;
  localparam int WIDTH_W  = 7;

  // width limits
  localparam logic [REQ_W-1:0] REQ_MAX       = 7'd64;
  localparam logic [PTR_W-1:0] PTR_MIN       = 7'd32;
  localparam logic [PTR_W-1:0] PTR_MAX       = 7'd64;
  localparam logic [PTR_W-1:0] PTR_RESET     = 7'd64;
  localparam logic [REQ_W-1:0] WIDE_BITS     = 7'd64;
  localparam logic [REQ_W-1:0] BOOL_BITS     = 7'd1;

  // attribute kind codes
  localparam logic [KIND_W-1:0] KIND_SIZED    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BOOL     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WIDE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POINTER  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COLUMNAR = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BLOB     = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] attr_kind;
    logic [REQ_W-1:0]  requested_bits;
    logic              dynamic;
  } rbfp_in_t;

  typedef struct packed {
    logic [OFF_W-1:0]   bit_offset;
    logic [WIDTH_W-1:0] bit_width;
    logic               dynamic_out;
    logic               pointer_slot;
    logic               store_full;
  } rbfp_out_t;

  // placement class of a captured request
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_BIG,
    CLS_SMALL
  } rbfp_cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_SCAN,
    S_EMIT
  } rbfp_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic res_none;
    logic res_full;
    logic big_start;
    logic fill_step;
    logic scan_start;
    logic scan_step;
    logic place_found;
    logic place_append;
    logic out_load;
  } rbfp_cmd_t;

  // datapath to controller
  typedef struct packed {
    rbfp_cls_t cls;
    logic      big_full;
    logic      count_zero;
    logic      fill_last;
    logic      fit;
    logic      scan_last;
    logic      count_at_max;
    logic      out_free;
  } rbfp_status_t;

endpackage

// File: src/rbfp_ram.sv
// ----------------------------------------------------------------------------
// rbfp_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/rbfp_ctrl.sv
// ----------------------------------------------------------------------------
// rbfp_ctrl: sequencer of the row bit field packer
// Walks each request through decode, item fill or first-fit scan, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module rbfp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rbfp_pkg::rbfp_status_t status,
  output rbfp_pkg::rbfp_cmd_t    cmd
);

  import rbfp_pkg::*;

  rbfp_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.cls)
          CLS_BIG: begin
            if (status.big_full) begin
              cmd.res_full = 1'b1;
              state_next   = S_EMIT;
            end else begin
              cmd.big_start = 1'b1;
              state_next    = S_FILL;
            end
          end
          CLS_SMALL: begin
            if (status.count_zero) begin
              cmd.place_append = 1'b1;
              state_next       = S_EMIT;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            cmd.res_none = 1'b1;
            state_next   = S_EMIT;
          end
        endcase
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        if (status.fit) begin
          cmd.place_found = 1'b1;
          state_next      = S_EMIT;
        end else if (status.scan_last) begin
          if (status.count_at_max) begin
            cmd.res_full = 1'b1;
          end else begin
            cmd.place_append = 1'b1;
          end
          state_next = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // the captured request must keep its class while it is being placed
  a_fill_is_big: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (status.cls == CLS_BIG))
    else $error("fill running for a request that is not whole-item");

  a_scan_is_small: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (status.cls == CLS_SMALL))
    else $error("scan running for a request that is not sub-item");

endmodule

// File: src/rbfp_datapath.sv
// ----------------------------------------------------------------------------
// rbfp_datapath: storage and arithmetic of the row bit field packer
// Holds the pointer width register, the used-bits RAM, the item count,
// the scan and fill counters, the pending result and the output register.
// ----------------------------------------------------------------------------
module rbfp_datapath #(
  parameter int ITEM_BITS = rbfp_pkg::ITEM_BITS_DEF,
  parameter int MAX_ITEMS = rbfp_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [rbfp_pkg::PTR_W-1:0]   cfg_wr_data,
  input  rbfp_pkg::rbfp_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rbfp_pkg::rbfp_out_t          out_data,
  input  rbfp_pkg::rbfp_cmd_t          cmd,
  output rbfp_pkg::rbfp_status_t       status
);

  import rbfp_pkg::*;

  localparam int UB_W   = $clog2(ITEM_BITS + 1);
  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int N_MAX  = (64 + ITEM_BITS - 1) / ITEM_BITS;
  localparam int N_W    = $clog2(N_MAX + 1);
  localparam int SUM_W  = ((CNT_W > N_W) ? CNT_W : N_W) + 1;
  localparam int PW     = ((CNT_W + 7) > OFF_W) ? (CNT_W + 7) : OFF_W;

  logic [PTR_W-1:0]   pointer_bits;
  rbfp_in_t           cap;
  logic [CNT_W-1:0]   item_count;
  logic [IDX_W-1:0]   scan_idx;
  logic [N_W-1:0]     fill_j;

  logic [OFF_W-1:0]   res_offset;
  logic [WIDTH_W-1:0] res_width;
  logic               res_slot;
  logic               res_full;

  logic [REQ_W-1:0]   req_sat;
  logic [REQ_W-1:0]   sized_bits;
  logic [PTR_W-1:0]   ptr_sat;
  logic [REQ_W-1:0]   bits;
  logic [WIDTH_W-1:0] none_width;
  rbfp_cls_t          cls;
  logic               is_pointer;
  logic [N_W-1:0]     n_items;
  logic [SUM_W-1:0]   count_plus_n;
  logic [PW-1:0]      cnt_prod;
  logic [PW-1:0]      idx_prod;

  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [UB_W-1:0]    ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [UB_W-1:0]    ram_rd_data;

  // pointer width register
  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_bits <= PTR_RESET;
    end else if (cfg_wr_en) begin
      pointer_bits <= cfg_wr_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap <= in_data;
    end
  end

  // width decode from the captured request
  always_comb begin
    req_sat    = (cap.requested_bits > REQ_MAX) ? REQ_MAX : cap.requested_bits;
    sized_bits = (req_sat == '0) ? REQ_W'(ITEM_BITS) : req_sat;
    if (pointer_bits < PTR_MIN) begin
      ptr_sat = PTR_MIN;
    end else if (pointer_bits > PTR_MAX) begin
      ptr_sat = PTR_MAX;
    end else begin
      ptr_sat = pointer_bits;
    end
    bits       = sized_bits;
    none_width = '0;
    cls        = CLS_NONE;
    case (cap.attr_kind)
      KIND_BOOL:     bits = BOOL_BITS;
      KIND_WIDE:     bits = WIDE_BITS;
      KIND_POINTER:  bits = ptr_sat;
      KIND_COLUMNAR: none_width = sized_bits;
      default:       bits = sized_bits;
    endcase
    if (cap.attr_kind inside {KIND_SIZED, KIND_BOOL, KIND_WIDE, KIND_POINTER}) begin
      cls = ({1'b0, bits} >= 8'(ITEM_BITS)) ? CLS_BIG : CLS_SMALL;
    end
  end

  assign is_pointer   = (cap.attr_kind == KIND_POINTER);
  assign n_items      = N_W'((8'(bits) + 8'(ITEM_BITS - 1)) / ITEM_BITS);
  assign count_plus_n = SUM_W'(item_count) + SUM_W'(n_items);
  assign cnt_prod     = PW'(item_count) * PW'(ITEM_BITS);
  assign idx_prod     = PW'(scan_idx) * PW'(ITEM_BITS);

  // status toward the controller
  assign status.cls          = cls;
  assign status.big_full     = (count_plus_n > SUM_W'(MAX_ITEMS));
  assign status.count_zero   = (item_count == '0);
  assign status.fill_last    = (fill_j == n_items - N_W'(1));
  assign status.fit          = (8'(ram_rd_data) + 8'(bits) <= 8'(ITEM_BITS));
  assign status.scan_last    = (CNT_W'(scan_idx) + CNT_W'(1) == item_count);
  assign status.count_at_max = (item_count == CNT_W'(MAX_ITEMS));
  assign status.out_free     = !out_valid || out_ready;

  // item count
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
    end else if (cmd.fill_step && status.fill_last) begin
      item_count <= CNT_W'(count_plus_n);
    end else if (cmd.place_append) begin
      item_count <= item_count + CNT_W'(1);
    end
  end

  // scan index and fill counter
  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.scan_step) begin
      scan_idx <= ram_rd_addr;
    end
    if (cmd.big_start) begin
      fill_j <= '0;
    end else if (cmd.fill_step) begin
      fill_j <= fill_j + N_W'(1);
    end
  end

  // used-bits RAM ports
  always_comb begin
    ram_wr_en   = cmd.fill_step || cmd.place_found || cmd.place_append;
    ram_wr_addr = IDX_W'(item_count);
    ram_wr_data = UB_W'(bits);
    if (cmd.fill_step) begin
      ram_wr_addr = IDX_W'(SUM_W'(item_count) + SUM_W'(fill_j));
      ram_wr_data = UB_W'(ITEM_BITS);
    end else if (cmd.place_found) begin
      ram_wr_addr = scan_idx;
      ram_wr_data = ram_rd_data + UB_W'(bits);
    end
    ram_rd_en   = cmd.scan_start || cmd.scan_step;
    ram_rd_addr = cmd.scan_start ? '0 : scan_idx + IDX_W'(1);
  end

  rbfp_ram #(
    .WIDTH (UB_W),
    .DEPTH (MAX_ITEMS)
  ) u_used_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.res_none) begin
      res_offset <= '0;
      res_width  <= none_width;
      res_slot   <= 1'b0;
      res_full   <= 1'b0;
    end else if (cmd.res_full) begin
      res_offset <= '0;
      res_width  <= '0;
      res_slot   <= 1'b0;
      res_full   <= 1'b1;
    end else if (cmd.big_start || cmd.place_append) begin
      res_offset <= OFF_W'(cnt_prod);
      res_width  <= bits;
      res_slot   <= is_pointer;
      res_full   <= 1'b0;
    end else if (cmd.place_found) begin
      res_offset <= OFF_W'(idx_prod + PW'(ram_rd_data));
      res_width  <= bits;
      res_slot   <= is_pointer;
      res_full   <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.bit_offset   <= res_offset;
      out_data.bit_width    <= res_width;
      out_data.dynamic_out  <= cap.dynamic;
      out_data.pointer_slot <= res_slot;
      out_data.store_full   <= res_full;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_W'(MAX_ITEMS))
    else $error("item count beyond store depth");

  a_full_result_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.store_full) |->
      (out_data.bit_offset == '0 && out_data.bit_width == '0 && !out_data.pointer_slot))
    else $error("full result carries an allocation");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (CNT_W'(scan_idx) + CNT_W'(1) < item_count))
    else $error("scan stepped past the last item in use");

endmodule

// File: src/row_bit_field_packer_core.sv
// ----------------------------------------------------------------------------
// row_bit_field_packer_core: first-fit bit field placement in a row
// Assigns each attribute request a bit offset and width within a row of
// ITEM_BITS-wide items and tracks the used bits of every item.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready carry one attribute request, out_valid/out_ready one
//    placement result. One request is in flight at a time; in_ready is high
//    while the sequencer is idle, and the result sits in an output register
//    so the next request is taken while the receiver still holds it.
//  - cfg_wr_en/cfg_wr_data write the pointer width; write only when idle.
//  - Columnar, blob and unknown kinds, store-full whole-item requests and a
//    sub-item request into an empty row go from decode straight to the
//    result; a whole-item request fills its n items in turn, and a sub-item
//    request scans the used-bits RAM, one entry per cycle, until an item
//    has room or the last item in use is reached. The scan through that RAM
//    port sets the rate.
//  - A new request can be taken in the cycle after the result is loaded.
//  - Reset clears the item count and sets the pointer width to 64. The RAM
//    is not cleared; only entries below the item count are ever read.
//  - If the receiver stalls with a result still held, the next result waits
//    in the sequencer until the output register frees, and no request is
//    taken meanwhile.
module row_bit_field_packer_core #(
  parameter int ITEM_BITS = rbfp_pkg::ITEM_BITS_DEF,
  parameter int MAX_ITEMS = rbfp_pkg::MAX_ITEMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [rbfp_pkg::PTR_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rbfp_pkg::rbfp_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rbfp_pkg::rbfp_out_t        out_data
);

  import rbfp_pkg::*;

  rbfp_cmd_t    cmd;
  rbfp_status_t status;

  // sequencer
  rbfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and arithmetic
  rbfp_datapath #(
    .ITEM_BITS (ITEM_BITS),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// File: tb/row_bit_field_packer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_bit_field_packer_core_tb: self-checking bench for the bit field packer
// Sends attribute requests over valid/ready, predicts each placement from a
// local model of the row's per-item usage, and compares every result field.
// ----------------------------------------------------------------------------
module row_bit_field_packer_core_tb;
  import rbfp_pkg::*;

  localparam int ITEM_BITS = ITEM_BITS_DEF;
  localparam int MAX_ITEMS = MAX_ITEMS_DEF;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [PTR_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  rbfp_in_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  rbfp_out_t        out_data;

  // local copy of the row state and the pointer width register
  int               used_bits [MAX_ITEMS];
  int               row_items = 0;
  logic [PTR_W-1:0] ptr_width = PTR_RESET;

  rbfp_out_t        expected_places [$];
  rbfp_out_t        last_place;
  int               mismatches = 0;
  int               hold_off = 0;
  bit               steady = 1'b0;

  row_bit_field_packer_core #(
    .ITEM_BITS(ITEM_BITS),
    .MAX_ITEMS(MAX_ITEMS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // first-fit placement of one request against the local row state
  function automatic rbfp_out_t place_attr(rbfp_in_t req);
    rbfp_out_t res;
    int        need;
    int        n;
    int        slot;
    bit        fits;
    res = '0;
    res.dynamic_out = req.dynamic;
    need = (req.requested_bits > REQ_MAX) ? int'(REQ_MAX) : int'(req.requested_bits);
    if (need == 0) need = ITEM_BITS;
    case (req.attr_kind)
      KIND_BOOL:    need = int'(BOOL_BITS);
      KIND_WIDE:    need = int'(WIDE_BITS);
      KIND_POINTER: begin
        if (ptr_width < PTR_MIN) need = int'(PTR_MIN);
        else if (ptr_width > PTR_MAX) need = int'(PTR_MAX);
        else need = int'(ptr_width);
      end
      default: ;
    endcase
    if (req.attr_kind == KIND_COLUMNAR) begin
      res.bit_width = WIDTH_W'(need);
    end else if (req.attr_kind >= KIND_BLOB) begin
      // blob and unknown kinds take no space
    end else if (need >= ITEM_BITS) begin
      // whole items appended at the end
      n = (need + ITEM_BITS - 1) / ITEM_BITS;
      if (row_items + n > MAX_ITEMS) begin
        res.store_full = 1'b1;
      end else begin
        res.bit_offset = OFF_W'(row_items * ITEM_BITS);
        for (int i = 0; i < n; i++) used_bits[row_items + i] = ITEM_BITS;
        row_items += n;
        res.bit_width = WIDTH_W'(need);
        res.pointer_slot = (req.attr_kind == KIND_POINTER);
      end
    end else begin
      // first item with room, else one new item
      slot = 0;
      fits = 1'b0;
      while (slot < row_items && !fits) begin
        if (used_bits[slot] + need <= ITEM_BITS) fits = 1'b1;
        else slot++;
      end
      if (!fits) begin
        if (row_items >= MAX_ITEMS) begin
          res.store_full = 1'b1;
        end else begin
          used_bits[row_items] = 0;
          row_items++;
        end
      end
      if (!res.store_full) begin
        res.bit_offset = OFF_W'(slot * ITEM_BITS + used_bits[slot]);
        used_bits[slot] += need;
        res.bit_width = WIDTH_W'(need);
        res.pointer_slot = (req.attr_kind == KIND_POINTER);
      end
    end
    return res;
  endfunction

  // drive one request, predict on accept, then maybe idle a while
  task automatic send_req(input logic [KIND_W-1:0] kind, input int bits, input bit dyn);
    rbfp_in_t req;
    int       gap;
    req.attr_kind = kind;
    req.requested_bits = bits[REQ_W-1:0];
    req.dynamic = dyn;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    last_place = place_attr(req);
    expected_places.push_back(last_place);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_places.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ptr_width(input logic [PTR_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    ptr_width = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_miss(input string what, input rbfp_out_t exp, input rbfp_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s: expected off %0d width %0d dyn %0b slot %0b full %0b, ",
                "got off %0d width %0d dyn %0b slot %0b full %0b"},
               what, exp.bit_offset, exp.bit_width, exp.dynamic_out, exp.pointer_slot,
               exp.store_full, got.bit_offset, got.bit_width, got.dynamic_out,
               got.pointer_slot, got.store_full);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_places.size() == 0) begin
        report_miss("unexpected result", '0, out_data);
      end else begin
        if (out_data.bit_offset !== expected_places[0].bit_offset ||
            out_data.bit_width !== expected_places[0].bit_width ||
            out_data.dynamic_out !== expected_places[0].dynamic_out ||
            out_data.pointer_slot !== expected_places[0].pointer_slot ||
            out_data.store_full !== expected_places[0].store_full)
          report_miss("mismatch", expected_places[0], out_data);
        void'(expected_places.pop_front());
      end
    end
  end

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_off  <= 0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off  <= hold_off - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) hold_off <= pick_gap();
    end
  end

  // every kind, field extremes, saturation and the special kinds
  task automatic test_kinds();
    send_req(KIND_SIZED, 0, 1'b0);
    send_req(KIND_SIZED, 64, 1'b1);
    send_req(KIND_SIZED, 127, 1'b0);
    send_req(KIND_SIZED, 1, 1'b1);
    send_req(KIND_SIZED, 31, 1'b0);
    send_req(KIND_BOOL, 0, 1'b1);
    send_req(KIND_WIDE, 5, 1'b0);
    send_req(KIND_POINTER, 0, 1'b1);
    send_req(KIND_COLUMNAR, 0, 1'b0);
    send_req(KIND_COLUMNAR, 100, 1'b1);
    send_req(KIND_BLOB, 127, 1'b1);
    send_req(3'd6, 12, 1'b0);
    send_req(3'd7, 127, 1'b1);
    send_req(KIND_SIZED, 33, 1'b1);
    send_req(KIND_SIZED, 16, 1'b0);
  endtask

  // pointer width register including out-of-range values
  task automatic test_pointer_widths();
    logic [PTR_W-1:0] widths [8] = '{7'd0, 7'd127, 7'd32, 7'd64, 7'd31, 7'd33, 7'd96, 7'd63};
    foreach (widths[i]) begin
      write_ptr_width(widths[i]);
      send_req(KIND_POINTER, int'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    end
  endtask

  // random requests, mostly small so the first-fit scan goes deep
  task automatic test_random_mix(input int count, input bit quiet);
    int               roll;
    int               bits;
    logic [KIND_W-1:0] kind;
    steady = quiet;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) kind = KIND_SIZED;
      else if (roll < 65) kind = KIND_BOOL;
      else if (roll < 70) kind = KIND_WIDE;
      else if (roll < 76) kind = KIND_POINTER;
      else if (roll < 86) kind = KIND_COLUMNAR;
      else if (roll < 94) kind = KIND_BLOB;
      else kind = KIND_W'($urandom_range(6, 7));
      roll = $urandom_range(0, 99);
      if (roll < 55) bits = $urandom_range(1, 6);
      else if (roll < 75) bits = $urandom_range(7, 31);
      else if (roll < 85) bits = 0;
      else bits = $urandom_range(0, 127);
      send_req(kind, bits, 1'($urandom_range(0, 1)));
    end
    steady = 1'b0;
  endtask

  // fill the row, then whole-item and sub-item requests must report full
  task automatic test_store_full();
    while (row_items <= MAX_ITEMS - 2) send_req(KIND_WIDE, 0, 1'b1);
    while (row_items < MAX_ITEMS) send_req(KIND_SIZED, 0, 1'b0);
    send_req(KIND_WIDE, 0, 1'b0);
    send_req(KIND_POINTER, 0, 1'b1);
    do send_req(KIND_SIZED, 31, 1'b1); while (!last_place.store_full);
    send_req(KIND_SIZED, 31, 1'b0);
    send_req(KIND_COLUMNAR, 7, 1'b1);
    send_req(KIND_BLOB, 0, 1'b0);
    send_req(KIND_BOOL, 0, 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_kinds();
    test_pointer_widths();
    write_ptr_width(PTR_W'($urandom_range(0, 127)));
    test_random_mix(300, 1'b0);
    write_ptr_width(7'd127);
    test_random_mix(200, 1'b1);
    write_ptr_width(7'd0);
    test_random_mix(300, 1'b0);
    write_ptr_width(PTR_W'($urandom_range(0, 127)));
    test_random_mix(300, 1'b0);
    test_store_full();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("row_bit_field_packer_core_tb passed");
    end else begin
      $display("row_bit_field_packer_core_tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("row_bit_field_packer_core_tb failed");
    $finish;
  end

endmodule
